/* sv/rcsgms_pkg.sv */
`default_nettype none

package rcsgms_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int PULSE_BITS_DEF = 16;

    localparam int IDLE_BITS      = 32;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_CLEAR_LOW  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_CLEAR_HIGH = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_IDLE       = 2'd2;

    localparam logic [31:0] CLEAR_LOW_RESET  = 32'd1300;
    localparam logic [31:0] CLEAR_HIGH_RESET = 32'd1700;
    localparam logic [31:0] IDLE_RESET       = 32'd1000000;

    typedef enum logic [1:0] {
        GESTURE_OFF,
        GESTURE_ARM,
        GESTURE_SWITCH
    } gesture_t;

    typedef struct packed {
        logic front_clear;
        logic rear_clear;
        logic front_on;
        logic rear_on;
        logic throttle_low;
        logic alive;
    } sample_flags_t;

endpackage

`default_nettype wire

/* sv/rcsgms_front.sv */
`default_nettype none

module rcsgms_front
    import rcsgms_pkg::*;
#(
    parameter int PULSE_BITS = PULSE_BITS_DEF
) (
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [PULSE_BITS-1:0] front_pulse,
    input  wire logic [PULSE_BITS-1:0] rear_pulse,
    input  wire logic [PULSE_BITS-1:0] throttle_pulse,
    input  wire logic                  link_alive,
    input  wire logic [PULSE_BITS-1:0] clear_low,
    input  wire logic [PULSE_BITS-1:0] clear_high,
    input  wire logic                  q_full,
    output logic                       q_push,
    output sample_flags_t              q_flags
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_flags.front_clear  = (front_pulse <= clear_low) || (front_pulse >= clear_high);
        q_flags.rear_clear   = (rear_pulse <= clear_low) || (rear_pulse >= clear_high);
        q_flags.front_on     = front_pulse >= clear_high;
        q_flags.rear_on      = rear_pulse >= clear_high;
        q_flags.throttle_low = throttle_pulse < clear_low;
        q_flags.alive        = link_alive;
    end

endmodule

`default_nettype wire

/* sv/rcsgms_queue.sv */
`default_nettype none

module rcsgms_queue
    import rcsgms_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic      [WIDTH-1:0] pop_data
);

    localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]      entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    assign full      = count_reg == COUNT_BITS'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* sv/rcsgms_back.sv */
`default_nettype none

module rcsgms_back
    import rcsgms_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_valid,
    output logic                      q_pop,
    input  wire sample_flags_t        q_flags,
    input  wire logic [TIME_BITS-1:0] q_time,
    input  wire logic [IDLE_BITS-1:0] idle_timeout,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_control_active,
    output logic [1:0]                m_gesture_state,
    output logic                      m_indicator_mode
);

    localparam int CMP_BITS = (TIME_BITS > IDLE_BITS) ? TIME_BITS : IDLE_BITS;

    gesture_t             gesture_reg, gesture_next;
    logic                 active_reg, active_next;
    logic                 fnow_reg, fnow_next;
    logic                 rnow_reg, rnow_next;
    logic                 fbef_reg, fbef_next;
    logic                 rbef_reg, rbef_next;
    logic [TIME_BITS-1:0] stamp_reg, stamp_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_active_reg;
    logic [1:0]           m_gesture_reg;

    logic [TIME_BITS-1:0] elapsed;
    logic                 idle;
    logic                 flip;
    logic                 fon, ron;

    assign fon     = q_flags.front_on;
    assign ron     = q_flags.rear_on;
    assign elapsed = q_time - stamp_reg;
    assign idle    = CMP_BITS'(elapsed) > CMP_BITS'(idle_timeout);
    assign flip    = (fon != ron) && (fon != fbef_reg) && (ron != rbef_reg);
    assign q_pop   = q_valid && (!m_valid_reg || m_ready);

    always_comb begin
        gesture_next = gesture_reg;
        active_next  = active_reg;
        fnow_next    = fnow_reg;
        rnow_next    = rnow_reg;
        fbef_next    = fbef_reg;
        rbef_next    = rbef_reg;
        stamp_next   = stamp_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (q_pop) begin
            m_valid_next = 1'b1;
            if ((active_reg && q_flags.throttle_low) || !q_flags.alive) begin
                gesture_next = GESTURE_OFF;
                active_next  = 1'b0;
            end
            if (q_flags.front_clear && q_flags.rear_clear) begin
                fnow_next = fon;
                rnow_next = ron;
                unique case (gesture_next)
                    GESTURE_OFF: begin
                        stamp_next = q_time;
                        if (fon != ron) begin
                            fbef_next    = fon;
                            rbef_next    = ron;
                            gesture_next = GESTURE_ARM;
                        end
                    end
                    GESTURE_ARM: begin
                        if (flip) begin
                            fbef_next    = fon;
                            rbef_next    = ron;
                            gesture_next = GESTURE_SWITCH;
                        end else if (fon == ron) begin
                            if (idle) begin
                                fnow_next    = 1'b0;
                                rnow_next    = 1'b0;
                                fbef_next    = 1'b0;
                                rbef_next    = 1'b0;
                                gesture_next = GESTURE_OFF;
                            end
                        end else begin
                            stamp_next = q_time;
                        end
                    end
                    GESTURE_SWITCH: begin
                        // after an idle reset no flip can follow
                        if (idle) begin
                            fnow_next    = 1'b0;
                            rnow_next    = 1'b0;
                            fbef_next    = 1'b0;
                            rbef_next    = 1'b0;
                            gesture_next = GESTURE_OFF;
                        end else if (flip) begin
                            fbef_next    = fon;
                            rbef_next    = ron;
                            gesture_next = GESTURE_OFF;
                            active_next  = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gesture_reg <= GESTURE_OFF;
            active_reg  <= 1'b0;
            fnow_reg    <= 1'b0;
            rnow_reg    <= 1'b0;
            fbef_reg    <= 1'b0;
            rbef_reg    <= 1'b0;
            stamp_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            gesture_reg <= gesture_next;
            active_reg  <= active_next;
            fnow_reg    <= fnow_next;
            rnow_reg    <= rnow_next;
            fbef_reg    <= fbef_next;
            rbef_reg    <= rbef_next;
            stamp_reg   <= stamp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_active_reg  <= active_next;
            m_gesture_reg <= gesture_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_control_active = m_active_reg;
    assign m_gesture_state  = m_gesture_reg;
    assign m_indicator_mode = m_active_reg;

endmodule

`default_nettype wire

/* sv/rc_switch_gesture_mode_select_core.sv */
// Path: a beat accepted on the s_ side is written into the queue, then popped into the
// gesture sequencer's output register, which drives the m_ side.
// Throughput: one beat per cycle; a two-entry queue between classifier and gesture
// sequencer absorbs stalls, s_ready drops only when that queue is full.
// Reset: aresetn is synchronous and active low; it clears the gesture, control flag,
// switch history, queue and output valid, and restores the register defaults.
`default_nettype none

module rc_switch_gesture_mode_select_core
    import rcsgms_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int PULSE_BITS = PULSE_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [PULSE_BITS-1:0]     s_front_pulse,
    input  wire logic [PULSE_BITS-1:0]     s_rear_pulse,
    input  wire logic [PULSE_BITS-1:0]     s_throttle_pulse,
    input  wire logic                      s_link_alive,
    input  wire logic [TIME_BITS-1:0]      s_time_now,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_control_active,
    output logic [1:0]                     m_gesture_state,
    output logic                           m_indicator_mode
);

    localparam int Q_WIDTH = $bits(sample_flags_t) + TIME_BITS;

    logic [PULSE_BITS-1:0] clear_low_reg;
    logic [PULSE_BITS-1:0] clear_high_reg;
    logic [IDLE_BITS-1:0]  idle_timeout_reg;

    logic                  q_full, q_push, q_pop, q_not_empty;
    sample_flags_t         push_flags, pop_flags;
    logic [TIME_BITS-1:0]  pop_time;
    logic [Q_WIDTH-1:0]    pop_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_low_reg    <= PULSE_BITS'(CLEAR_LOW_RESET);
            clear_high_reg   <= PULSE_BITS'(CLEAR_HIGH_RESET);
            idle_timeout_reg <= IDLE_BITS'(IDLE_RESET);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IDX_CLEAR_LOW:  clear_low_reg    <= cfg_wdata[PULSE_BITS-1:0];
                CFG_IDX_CLEAR_HIGH: clear_high_reg   <= cfg_wdata[PULSE_BITS-1:0];
                CFG_IDX_IDLE:       idle_timeout_reg <= cfg_wdata[IDLE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    rcsgms_front #(
        .PULSE_BITS(PULSE_BITS)
    ) u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .front_pulse   (s_front_pulse),
        .rear_pulse    (s_rear_pulse),
        .throttle_pulse(s_throttle_pulse),
        .link_alive    (s_link_alive),
        .clear_low     (clear_low_reg),
        .clear_high    (clear_high_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_flags       (push_flags)
    );

    rcsgms_queue #(
        .WIDTH(Q_WIDTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data({push_flags, s_time_now}),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .pop_data (pop_data)
    );

    assign pop_flags = pop_data[Q_WIDTH-1:TIME_BITS];
    assign pop_time  = pop_data[TIME_BITS-1:0];

    rcsgms_back #(
        .TIME_BITS(TIME_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_not_empty),
        .q_pop           (q_pop),
        .q_flags         (pop_flags),
        .q_time          (pop_time),
        .idle_timeout    (idle_timeout_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_control_active(m_control_active),
        .m_gesture_state (m_gesture_state),
        .m_indicator_mode(m_indicator_mode)
    );

endmodule

`default_nettype wire

/* sv/rcsgms_checker.sv */
`default_nettype none

module rcsgms_checker
    import rcsgms_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_control_active,
    input wire logic [1:0] m_gesture_state,
    input wire logic       m_indicator_mode
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_control_active)
            && $stable(m_gesture_state))
        else $error("stalled result beat changed");

    a_indicator_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_indicator_mode == m_control_active)
        else $error("indicator disagrees with control flag");

    a_gesture_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_gesture_state <= 2'(GESTURE_SWITCH))
        else $error("unused gesture code on output");

endmodule

bind rc_switch_gesture_mode_select_core rcsgms_checker u_rcsgms_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_control_active(m_control_active),
    .m_gesture_state (m_gesture_state),
    .m_indicator_mode(m_indicator_mode)
);

`default_nettype wire

/* test/rc_switch_gesture_mode_select_core_tb.sv */
`timescale 1ns / 1ps

module rc_switch_gesture_mode_select_core_tb;
    import rcsgms_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int HOLD_LEN       = 800;
    localparam int PHASE_ITEMS    = 215;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_UNUSED = 2'd3;

    typedef enum int {
        PULSE_OFF,
        PULSE_ON,
        PULSE_MID
    } pulse_kind_t;

    typedef struct {
        logic       active;
        logic [1:0] state;
        logic       indicator;
    } mode_result_t;

    class gesture_scoreboard;
        logic [PULSE_BITS_DEF-1:0] low_th;
        logic [PULSE_BITS_DEF-1:0] high_th;
        logic [IDLE_BITS-1:0]      idle_lim;
        gesture_t                  gesture;
        logic                      active;
        logic                      front_on;
        logic                      rear_on;
        logic                      front_prev;
        logic                      rear_prev;
        logic [TIME_BITS_DEF-1:0]  stamp;
        mode_result_t              expected_modes[$];
        int                        errors;

        function new();
            low_th     = CLEAR_LOW_RESET[PULSE_BITS_DEF-1:0];
            high_th    = CLEAR_HIGH_RESET[PULSE_BITS_DEF-1:0];
            idle_lim   = IDLE_RESET;
            gesture    = GESTURE_OFF;
            active     = 1'b0;
            front_on   = 1'b0;
            rear_on    = 1'b0;
            front_prev = 1'b0;
            rear_prev  = 1'b0;
            stamp      = '0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_IDX_CLEAR_LOW: low_th = data[PULSE_BITS_DEF-1:0];
                CFG_IDX_CLEAR_HIGH: high_th = data[PULSE_BITS_DEF-1:0];
                CFG_IDX_IDLE: idle_lim = data[IDLE_BITS-1:0];
                default: ;
            endcase
        endfunction

        function bit is_clear(logic [PULSE_BITS_DEF-1:0] p);
            return (p <= low_th) || (p >= high_th);
        endfunction

        function bit flipped();
            return (front_on != rear_on) && (front_on != front_prev) && (rear_on != rear_prev);
        endfunction

        function void latch_pattern();
            front_prev = front_on;
            rear_prev  = rear_on;
        endfunction

        function void idle_check(logic [TIME_BITS_DEF-1:0] now);
            logic [TIME_BITS_DEF-1:0] elapsed;
            elapsed = now - stamp;
            if (elapsed > idle_lim) begin
                front_on   = 1'b0;
                rear_on    = 1'b0;
                front_prev = 1'b0;
                rear_prev  = 1'b0;
                gesture    = GESTURE_OFF;
            end
        endfunction

        function void note_sample(logic [PULSE_BITS_DEF-1:0] front, logic [PULSE_BITS_DEF-1:0] rear,
                                  logic [PULSE_BITS_DEF-1:0] thr, logic alive,
                                  logic [TIME_BITS_DEF-1:0] now);
            mode_result_t want;
            if ((active && thr < low_th) || !alive) begin
                gesture = GESTURE_OFF;
                active  = 1'b0;
            end
            if (is_clear(front) && is_clear(rear)) begin
                front_on = (front >= high_th);
                rear_on  = (rear >= high_th);
                case (gesture)
                    GESTURE_OFF: begin
                        stamp = now;
                        if (front_on != rear_on) begin
                            latch_pattern();
                            gesture = GESTURE_ARM;
                        end
                    end
                    GESTURE_ARM: begin
                        if (flipped()) begin
                            latch_pattern();
                            gesture = GESTURE_SWITCH;
                        end else if (front_on == rear_on) begin
                            idle_check(now);
                        end else begin
                            stamp = now;
                        end
                    end
                    GESTURE_SWITCH: begin
                        idle_check(now);
                        if (flipped()) begin
                            latch_pattern();
                            gesture = GESTURE_OFF;
                            active  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            want.active    = active;
            want.state     = gesture;
            want.indicator = active;
            expected_modes.push_back(want);
        endfunction

        function int pending();
            return expected_modes.size();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic act, logic [1:0] st, logic ind);
            mode_result_t want;
            if (expected_modes.size() == 0) begin
                report("result beat with nothing expected");
            end else begin
                want = expected_modes.pop_front();
                if (act !== want.active)
                    report($sformatf("control_active %b, expected %b", act, want.active));
                if (st !== want.state)
                    report($sformatf("gesture_state %0d, expected %0d", st, want.state));
                if (ind !== want.indicator)
                    report($sformatf("indicator_mode %b, expected %b", ind, want.indicator));
            end
        endtask
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [PULSE_BITS_DEF-1:0] s_front_pulse = '0;
    logic [PULSE_BITS_DEF-1:0] s_rear_pulse = '0;
    logic [PULSE_BITS_DEF-1:0] s_throttle_pulse = '0;
    logic                      s_link_alive = 1'b0;
    logic [TIME_BITS_DEF-1:0]  s_time_now = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_control_active;
    logic [1:0]                m_gesture_state;
    logic                      m_indicator_mode;

    gesture_scoreboard         sb = new();
    int                        tx_idle_pct = 0;
    int                        rx_stall_pct = 0;
    logic                      hold_tog = 1'b0;
    logic                      hold_seen = 1'b0;
    int                        hold_left = 0;
    int                        quiet = 0;
    logic                      pat_front = 1'b1;
    logic [TIME_BITS_DEF-1:0]  t_now = '0;

    rc_switch_gesture_mode_select_core DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_front_pulse    (s_front_pulse),
        .s_rear_pulse     (s_rear_pulse),
        .s_throttle_pulse (s_throttle_pulse),
        .s_link_alive     (s_link_alive),
        .s_time_now       (s_time_now),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_control_active (m_control_active),
        .m_gesture_state  (m_gesture_state),
        .m_indicator_mode (m_indicator_mode)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_left <= HOLD_LEN;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_control_active, m_gesture_state, m_indicator_mode);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("rc_switch_gesture_mode_select_core_tb: errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_sample(input logic [PULSE_BITS_DEF-1:0] front,
                               input logic [PULSE_BITS_DEF-1:0] rear,
                               input logic [PULSE_BITS_DEF-1:0] thr,
                               input logic alive,
                               input logic [TIME_BITS_DEF-1:0] now);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_front_pulse    <= front;
        s_rear_pulse     <= rear;
        s_throttle_pulse <= thr;
        s_link_alive     <= alive;
        s_time_now       <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_sample(front, rear, thr, alive, now);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.set_reg(idx, data);
    endtask

    task automatic apply_config(input logic [PULSE_BITS_DEF-1:0] low,
                                input logic [PULSE_BITS_DEF-1:0] high,
                                input logic [IDLE_BITS-1:0] idle);
        write_reg(CFG_IDX_CLEAR_LOW, CFG_DATA_BITS'(low));
        write_reg(CFG_IDX_CLEAR_HIGH, CFG_DATA_BITS'(high));
        write_reg(CFG_IDX_IDLE, CFG_DATA_BITS'(idle));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [PULSE_BITS_DEF-1:0] pick_pulse(pulse_kind_t kind);
        int lo;
        int hi;
        lo = int'(sb.low_th);
        hi = int'(sb.high_th);
        case (kind)
            PULSE_OFF: return PULSE_BITS_DEF'($urandom_range(lo, 0));
            PULSE_ON: return PULSE_BITS_DEF'($urandom_range(16'hFFFF, hi));
            default: begin
                if (hi > lo + 1)
                    return PULSE_BITS_DEF'($urandom_range(hi - 1, lo + 1));
                return PULSE_BITS_DEF'($urandom);
            end
        endcase
    endfunction

    task automatic advance_time();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            t_now = t_now;
        else if (pick < 65)
            t_now = t_now + $urandom_range(sb.idle_lim >> 2, 0);
        else if (pick < 78)
            t_now = t_now + sb.idle_lim;
        else if (pick < 95)
            t_now = t_now + sb.idle_lim + $urandom_range(5, 1);
        else
            t_now = $urandom;
    endtask

    task automatic send_random_item();
        int                        pick;
        logic                      f_on;
        logic                      r_on;
        logic [PULSE_BITS_DEF-1:0] front;
        logic [PULSE_BITS_DEF-1:0] rear;
        logic [PULSE_BITS_DEF-1:0] thr;
        logic                      alive;
        pick = $urandom_range(99);
        if (pick < 70) begin
            if ($urandom_range(9) == 0) begin
                f_on = 1'($urandom_range(1));
                r_on = f_on;
            end else begin
                f_on = pat_front;
                r_on = !pat_front;
                if ($urandom_range(99) < 85)
                    pat_front = !pat_front;
            end
            front = pick_pulse(f_on ? PULSE_ON : PULSE_OFF);
            rear  = pick_pulse(r_on ? PULSE_ON : PULSE_OFF);
        end else if (pick < 88) begin
            front = pick_pulse(pulse_kind_t'($urandom_range(2)));
            rear  = pick_pulse(pulse_kind_t'($urandom_range(2)));
        end else begin
            front = PULSE_BITS_DEF'($urandom);
            rear  = PULSE_BITS_DEF'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 85)
            thr = PULSE_BITS_DEF'($urandom_range(16'hFFFF, int'(sb.low_th)));
        else if (pick < 95)
            thr = PULSE_BITS_DEF'($urandom_range(int'(sb.low_th), 0));
        else
            thr = PULSE_BITS_DEF'($urandom);
        alive = ($urandom_range(99) >= 3);
        advance_time();
        send_sample(front, rear, thr, alive, t_now);
    endtask

    task automatic run_phase(input logic [PULSE_BITS_DEF-1:0] low,
                             input logic [PULSE_BITS_DEF-1:0] high,
                             input logic [IDLE_BITS-1:0] idle,
                             input int tx_pct, input int rx_pct,
                             input logic [TIME_BITS_DEF-1:0] start, input bit hold);
        wait_for_results();
        apply_config(low, high, idle);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        t_now        = start;
        if (hold)
            hold_tog <= !hold_tog;
        repeat (PHASE_ITEMS) send_random_item();
    endtask

    initial begin
        logic [PULSE_BITS_DEF-1:0] rnd_low;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: 1300 / 1700, timeout 1000000
        send_sample(16'd0, 16'd0, 16'd0, 1'b0, 32'd0);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        send_sample(16'd1700, 16'd1300, 16'd1500, 1'b1, 32'd100);
        send_sample(16'd1301, 16'd1300, 16'd1500, 1'b1, 32'd200);
        send_sample(16'd1700, 16'd1699, 16'd1500, 1'b1, 32'd250);
        send_sample(16'd1700, 16'd0, 16'd1500, 1'b1, 32'd300);
        send_sample(16'd0, 16'd1700, 16'd1500, 1'b1, 32'd400);
        send_sample(16'd0, 16'hFFFF, 16'd1500, 1'b1, 32'd500);
        send_sample(16'hFFFF, 16'd0, 16'd1500, 1'b1, 32'd600);
        send_sample(16'd0, 16'd0, 16'd1300, 1'b1, 32'd700);
        send_sample(16'd0, 16'd0, 16'd1299, 1'b1, 32'd800);
        // low throttle without control: no release
        send_sample(16'd1700, 16'd0, 16'd0, 1'b1, 32'd900);
        // idle boundary while armed with an equal pattern
        send_sample(16'd0, 16'd0, 16'd1500, 1'b1, 32'd1000900);
        send_sample(16'd0, 16'd0, 16'd1500, 1'b1, 32'd1000901);
        // idle while awaiting the second flip
        send_sample(16'd1700, 16'd0, 16'd1500, 1'b1, 32'd2000000);
        send_sample(16'd0, 16'd1700, 16'd1500, 1'b1, 32'd2000100);
        send_sample(16'd1700, 16'd0, 16'd1500, 1'b1, 32'd3000101);
        // link loss releases before the same sample arms again
        send_sample(16'd1700, 16'd0, 16'd1500, 1'b1, 32'd3100000);
        send_sample(16'd0, 16'd1700, 16'd1500, 1'b1, 32'd3100010);
        send_sample(16'd1700, 16'd0, 16'd1500, 1'b0, 32'd3100020);
        send_sample(16'd0, 16'd1700, 16'd1500, 1'b1, 32'd3100030);
        send_sample(16'd1700, 16'd0, 16'd1500, 1'b1, 32'd3100040);
        send_sample(16'd1700, 16'd1700, 16'd1500, 1'b0, 32'd3100050);

        wait_for_results();
        write_reg(CFG_IDX_UNUSED, 32'hFFFF_FFFF);
        apply_config(16'd2000, 16'd1000, 32'd1000000);
        // overlapping thresholds: mid pulses read on
        send_sample(16'd1500, 16'd1500, 16'd2500, 1'b1, 32'd10);
        send_sample(16'd1500, 16'd0, 16'd2500, 1'b1, 32'd20);

        rnd_low = PULSE_BITS_DEF'($urandom_range(3000, 0));
        run_phase(16'd1300, 16'd1700, 32'd1000000, 0, 0, $urandom, 1'b0);
        run_phase(16'd0, 16'hFFFF, 32'hFFFF_FFFF, 64, 0, $urandom, 1'b0);
        run_phase(16'hFFFF, 16'd0, 32'd0, 0, 64, $urandom, 1'b0);
        run_phase(16'd1000, 16'd2000, 32'd50, 18, 18, $urandom, 1'b0);
        run_phase(16'd2000, 16'd1000, 32'd1000, 0, 0, $urandom, 1'b1);
        run_phase(rnd_low, rnd_low + 16'($urandom_range(2000, 2)), $urandom_range(5000, 0),
                  64, 0, $urandom, 1'b0);
        run_phase(16'd1300, 16'd1700, 32'd1000000, 0, 64, 32'hFFFF_F000, 1'b0);
        run_phase(PULSE_BITS_DEF'($urandom), PULSE_BITS_DEF'($urandom), $urandom,
                  18, 18, $urandom, 1'b0);
        run_phase(16'd1500, 16'd1501, 32'd20, 0, 0, $urandom, 1'b0);

        wait_for_results();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0)
            $display("rc_switch_gesture_mode_select_core_tb: clean");
        else
            $display("rc_switch_gesture_mode_select_core_tb: errors");
        $finish;
    end

endmodule

/* files.f */
sv/rcsgms_pkg.sv
sv/rcsgms_front.sv
sv/rcsgms_queue.sv
sv/rcsgms_back.sv
sv/rc_switch_gesture_mode_select_core.sv
sv/rcsgms_checker.sv
test/rc_switch_gesture_mode_select_core_tb.sv
